// ----- hdl/flbca_pkg.sv -----
package flbca_pkg;

    // Sizing
    localparam int HISTORY_DEPTH = 16;
    localparam int TIMER_BITS    = 24;
    localparam int REG_W         = 24;
    localparam int IDX_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
    localparam int CFG_IDX_W     = 3;
    localparam int ADDR_W        = 5;
    localparam int CODE_W        = 16;
    localparam int SEV_W         = 2;
    localparam int MAP_W         = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_GAP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_GAP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_BEEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_GAP = 3'd4;

    // Register reset values
    localparam logic [REG_W-1:0] RST_BLINK     = 24'd200000;
    localparam logic [REG_W-1:0] RST_MID_GAP   = 24'd600000;
    localparam logic [REG_W-1:0] RST_END_GAP   = 24'd1000000;
    localparam logic [REG_W-1:0] RST_LONG_BEEP = 24'd1000000;
    localparam logic [REG_W-1:0] RST_FAULT_GAP = 24'd500000;

    // Severity codes
    localparam logic [SEV_W-1:0] SEV_INFO    = 2'd0;
    localparam logic [SEV_W-1:0] SEV_WARNING = 2'd1;
    localparam logic [SEV_W-1:0] SEV_ERROR   = 2'd2;
    localparam logic [SEV_W-1:0] SEV_FATAL   = 2'd3;

    typedef enum logic [1:0] {
        REQ_REPORT = 2'd0,
        REQ_CLEAR  = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_START  = 2'd3
    } t_req;

    // Micro-operations issued to the datapath
    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_REPORT,
        UOP_CLEAR,
        UOP_TIMER_DEC,
        UOP_READ,
        UOP_ADVANCE,
        UOP_IDX_INC,
        UOP_IDX_ZERO,
        UOP_START_FAULT,
        UOP_GO_IDLE,
        UOP_EMIT
    } t_uop;

    // Jump conditions
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_EMPTY,
        COND_PH_IDLE,
        COND_TIMER_NZ,
        COND_PH_FGAP,
        COND_IDX_END
    } t_cond;

    // Sequencer to datapath
    typedef struct packed {
        logic accept;
        t_uop op;
        logic emit;
    } t_ctl;

    // Datapath flags for jump conditions
    typedef struct packed {
        logic empty;
        logic ph_idle;
        logic timer_nz;
        logic ph_fgap;
        logic idx_end;
    } t_stat;

    // Result payload
    typedef struct packed {
        logic             red_led;
        logic             green_led;
        logic             buzzer_on;
        logic             playing;
        logic [CNT_W-1:0] logged_count;
        logic [MAP_W-1:0] module_bitmap;
        logic             critical_seen;
    } t_rsp;

    // Duration register to timer load: zero counts as one tick, saturate to timer width
    function automatic logic [TIMER_BITS-1:0] dur_to_timer(input logic [REG_W-1:0] dur);
        logic [REG_W-1:0] d;
        logic [31:0]      w;
        logic [31:0]      tmax;
        d    = (dur == '0) ? '0 : dur - REG_W'(1);
        w    = 32'(d);
        tmax = 32'((64'd1 << TIMER_BITS) - 64'd1);
        if (w > tmax) begin
            w = tmax;
        end
        return w[TIMER_BITS-1:0];
    endfunction

endpackage

// ----- hdl/flbca_req_if.sv -----
interface flbca_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] fault_code;
    logic [1:0]  severity;

    modport source (output valid, output req_type, output fault_code, output severity,
                    input ready);
    modport sink   (input valid, input req_type, input fault_code, input severity,
                    output ready);
endinterface

// ----- hdl/flbca_rsp_if.sv -----
interface flbca_rsp_if;
    logic        valid;
    logic        ready;
    logic        red_led;
    logic        green_led;
    logic        buzzer_on;
    logic        playing;
    logic [4:0]  logged_count;
    logic [31:0] module_bitmap;
    logic        critical_seen;

    modport source (output valid, output red_led, output green_led, output buzzer_on,
                    output playing, output logged_count, output module_bitmap,
                    output critical_seen, input ready);
    modport sink   (input valid, input red_led, input green_led, input buzzer_on,
                    input playing, input logged_count, input module_bitmap,
                    input critical_seen, output ready);
endinterface

// ----- hdl/fault_log_blink_code_annunciator.sv -----
// Channel  | Dir | Fields                                          | Handshake
// i_req    | in  | req_type, fault_code, severity                  | valid/ready
// o_rsp    | out | red_led, green_led, buzzer_on, playing,         | valid/ready
//          |     | logged_count, module_bitmap, critical_seen      |
// i_cfg_*  | in  | i_cfg_idx, i_cfg_data                           | i_cfg_we
//
// Each item runs a short microprogram ending in an emit step: report and clear run one
// step; a tick stops when idle or counts a nonzero timer down, else steps the phase,
// or at a fault gap ends the fault and fetches the next entry or stops. A start on a
// nonempty log zeroes the index, reads the first entry and starts it; one item is in work at a time.
// A finished result sits in the output register; the next item may be taken meanwhile
// but its final step waits until that result is transferred.
// Synchronous active-low reset; no clearing pass, the history needs none.
module fault_log_blink_code_annunciator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    flbca_req_if.sink                        i_req,
    flbca_rsp_if.source                      o_rsp,
    input  logic                             i_cfg_we,
    input  logic [flbca_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [flbca_pkg::REG_W-1:0]      i_cfg_data
);
    import flbca_pkg::*;

    t_ctl  w_ctl;
    t_stat w_stat;
    t_rsp  w_rsp;
    logic  w_in_ready;
    logic  w_out_valid;

    // Microprogram sequencer
    flbca_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (w_in_ready),
        .i_req_type  (i_req.req_type),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_ctl       (w_ctl)
    );

    // Log, timers and result register
    flbca_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_fault_code (i_req.fault_code),
        .i_severity   (i_req.severity),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_stat       (w_stat),
        .o_rsp        (w_rsp)
    );

    assign i_req.ready         = w_in_ready;
    assign o_rsp.valid         = w_out_valid;
    assign o_rsp.red_led       = w_rsp.red_led;
    assign o_rsp.green_led     = w_rsp.green_led;
    assign o_rsp.buzzer_on     = w_rsp.buzzer_on;
    assign o_rsp.playing       = w_rsp.playing;
    assign o_rsp.logged_count  = w_rsp.logged_count;
    assign o_rsp.module_bitmap = w_rsp.module_bitmap;
    assign o_rsp.critical_seen = w_rsp.critical_seen;

endmodule

// ----- hdl/flbca_seq.sv -----
module flbca_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_req_type,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  flbca_pkg::t_stat      i_stat,
    output flbca_pkg::t_ctl       o_ctl
);
    import flbca_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        t_uop              op;
        t_cond             cond;
        logic [ADDR_W-1:0] target;
    } t_uword;

    // Program entry points
    localparam logic [ADDR_W-1:0] A_REPORT = 5'd0;
    localparam logic [ADDR_W-1:0] A_CLEAR  = 5'd1;
    localparam logic [ADDR_W-1:0] A_TICK   = 5'd2;
    localparam logic [ADDR_W-1:0] A_FGAP   = 5'd7;
    localparam logic [ADDR_W-1:0] A_STOP   = 5'd11;
    localparam logic [ADDR_W-1:0] A_START  = 5'd12;
    localparam logic [ADDR_W-1:0] A_EMIT   = 5'd16;

    // Control store
    function automatic t_uword rom(input logic [ADDR_W-1:0] a);
        t_uword w;
        case (a)
            5'd0:    w = '{UOP_REPORT,      COND_ALWAYS,   A_EMIT};
            5'd1:    w = '{UOP_CLEAR,       COND_ALWAYS,   A_EMIT};
            // tick: idle, count down, or step the phase
            5'd2:    w = '{UOP_NOP,         COND_PH_IDLE,  A_EMIT};
            5'd3:    w = '{UOP_TIMER_DEC,   COND_TIMER_NZ, A_EMIT};
            5'd4:    w = '{UOP_NOP,         COND_PH_FGAP,  A_FGAP};
            5'd5:    w = '{UOP_READ,        COND_NEVER,    A_EMIT};
            5'd6:    w = '{UOP_ADVANCE,     COND_ALWAYS,   A_EMIT};
            // end of one fault: next entry or stop
            5'd7:    w = '{UOP_IDX_INC,     COND_NEVER,    A_EMIT};
            5'd8:    w = '{UOP_NOP,         COND_IDX_END,  A_STOP};
            5'd9:    w = '{UOP_READ,        COND_NEVER,    A_EMIT};
            5'd10:   w = '{UOP_START_FAULT, COND_ALWAYS,   A_EMIT};
            5'd11:   w = '{UOP_GO_IDLE,     COND_ALWAYS,   A_EMIT};
            // start playback
            5'd12:   w = '{UOP_NOP,         COND_EMPTY,    A_EMIT};
            5'd13:   w = '{UOP_IDX_ZERO,    COND_NEVER,    A_EMIT};
            5'd14:   w = '{UOP_READ,        COND_NEVER,    A_EMIT};
            5'd15:   w = '{UOP_START_FAULT, COND_ALWAYS,   A_EMIT};
            5'd16:   w = '{UOP_EMIT,        COND_NEVER,    A_EMIT};
            default: w = '{UOP_NOP,         COND_ALWAYS,   A_EMIT};
        endcase
        return w;
    endfunction

    t_state            r_state;
    logic [ADDR_W-1:0] r_pc;
    logic              r_out_valid;
    t_uword            w_word;
    logic              w_take;
    logic              w_accept;
    logic              w_emit;
    logic [ADDR_W-1:0] w_entry;

    assign w_word     = rom(r_pc);
    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_emit     = (r_state == ST_RUN) && (w_word.op == UOP_EMIT)
                        && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    // Jump condition select
    always_comb begin
        case (w_word.cond)
            COND_NEVER:    w_take = 1'b0;
            COND_ALWAYS:   w_take = 1'b1;
            COND_EMPTY:    w_take = i_stat.empty;
            COND_PH_IDLE:  w_take = i_stat.ph_idle;
            COND_TIMER_NZ: w_take = i_stat.timer_nz;
            COND_PH_FGAP:  w_take = i_stat.ph_fgap;
            COND_IDX_END:  w_take = i_stat.idx_end;
            default:       w_take = 1'b0;
        endcase
    end

    // Dispatch on request type
    always_comb begin
        case (t_req'(i_req_type))
            REQ_REPORT: w_entry = A_REPORT;
            REQ_CLEAR:  w_entry = A_CLEAR;
            REQ_TICK:   w_entry = A_TICK;
            REQ_START:  w_entry = A_START;
            default:    w_entry = A_EMIT;
        endcase
    end

    // Control word to datapath
    always_comb begin
        o_ctl.accept = w_accept;
        o_ctl.emit   = w_emit;
        o_ctl.op     = ((r_state == ST_RUN) && (w_word.op != UOP_EMIT)) ? w_word.op : UOP_NOP;
    end

    // Step counter, state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a new result replaces one leaving in the same cycle
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_pc    <= w_entry;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (w_word.op == UOP_EMIT) begin
                        if (w_emit) begin
                            r_state <= ST_IDLE;
                        end
                    end else if (w_take) begin
                        r_pc <= w_word.target;
                    end else begin
                        r_pc <= r_pc + ADDR_W'(1);
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- hdl/flbca_dp.sv -----
module flbca_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  flbca_pkg::t_ctl                  i_ctl,
    input  logic [15:0]                      i_fault_code,
    input  logic [1:0]                       i_severity,
    input  logic                             i_cfg_we,
    input  logic [flbca_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [flbca_pkg::REG_W-1:0]      i_cfg_data,
    output flbca_pkg::t_stat                 o_stat,
    output flbca_pkg::t_rsp                  o_rsp
);
    import flbca_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RED_ON    = 4'd1,
        PH_RED_OFF   = 4'd2,
        PH_MID_GAP   = 4'd3,
        PH_GRN_ON    = 4'd4,
        PH_GRN_OFF   = 4'd5,
        PH_END_GAP   = 4'd6,
        PH_BUZ_ON    = 4'd7,
        PH_BUZ_OFF   = 4'd8,
        PH_FAULT_GAP = 4'd9
    } t_phase;

    // Configuration
    logic [REG_W-1:0] r_blink, r_mid_gap, r_end_gap, r_long_beep, r_fault_gap;

    // History store
    logic [CODE_W-1:0] r_hist_code [HISTORY_DEPTH];
    logic [SEV_W-1:0]  r_hist_sev  [HISTORY_DEPTH];
    logic [CODE_W-1:0] r_rd_code;
    logic [SEV_W-1:0]  r_rd_sev;

    // Held item
    logic [CODE_W-1:0] r_item_code;
    logic [SEV_W-1:0]  r_item_sev;

    // Log and playback state
    logic [CNT_W-1:0]      r_count, n_count;
    logic [MAP_W-1:0]      r_map, n_map;
    logic                  r_crit, n_crit;
    t_phase                r_phase, n_phase;
    logic [CNT_W-1:0]      r_index, n_index;
    logic [7:0]            r_blink_left, n_blink_left;
    logic [TIMER_BITS-1:0] r_timer, n_timer;

    logic [IDX_W-1:0] w_cur;
    logic             w_has_room;

    assign w_has_room = (r_count < CNT_W'(HISTORY_DEPTH));
    assign w_cur      = (r_index < CNT_W'(HISTORY_DEPTH)) ? r_index[IDX_W-1:0] : '0;

    // Flags for the sequencer
    always_comb begin
        o_stat.empty    = (r_count == '0);
        o_stat.ph_idle  = (r_phase == PH_IDLE);
        o_stat.timer_nz = (r_timer != '0);
        o_stat.ph_fgap  = (r_phase == PH_FAULT_GAP);
        o_stat.idx_end  = !((r_index < r_count) && (r_index < CNT_W'(HISTORY_DEPTH)));
    end

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink     <= RST_BLINK;
            r_mid_gap   <= RST_MID_GAP;
            r_end_gap   <= RST_END_GAP;
            r_long_beep <= RST_LONG_BEEP;
            r_fault_gap <= RST_FAULT_GAP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BLINK:     r_blink     <= i_cfg_data;
                CFG_MID_GAP:   r_mid_gap   <= i_cfg_data;
                CFG_END_GAP:   r_end_gap   <= i_cfg_data;
                CFG_LONG_BEEP: r_long_beep <= i_cfg_data;
                CFG_FAULT_GAP: r_fault_gap <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // History write on report, registered read of the current entry
    always_ff @(posedge i_clk) begin
        if (i_ctl.op == UOP_REPORT && w_has_room) begin
            r_hist_code[r_count[IDX_W-1:0]] <= r_item_code;
            r_hist_sev[r_count[IDX_W-1:0]]  <= r_item_sev;
        end
        if (i_ctl.op == UOP_READ) begin
            r_rd_code <= r_hist_code[w_cur];
            r_rd_sev  <= r_hist_sev[w_cur];
        end
        if (i_ctl.accept) begin
            r_item_code <= i_fault_code;
            r_item_sev  <= i_severity;
        end
    end

    // Micro-operation execution
    always_comb begin
        logic [7:0] bl_dec;
        bl_dec       = r_blink_left - 8'd1;
        n_count      = r_count;
        n_map        = r_map;
        n_crit       = r_crit;
        n_phase      = r_phase;
        n_index      = r_index;
        n_blink_left = r_blink_left;
        n_timer      = r_timer;
        case (i_ctl.op)
            UOP_REPORT: begin
                if (w_has_room) begin
                    n_count = r_count + CNT_W'(1);
                end
                n_map = r_map | (MAP_W'(1) << r_item_code[12:8]);
                if (r_item_sev == SEV_FATAL) begin
                    n_crit = 1'b1;
                end
            end
            UOP_CLEAR: begin
                n_count      = '0;
                n_map        = '0;
                n_crit       = 1'b0;
                n_phase      = PH_IDLE;
                n_index      = '0;
                n_blink_left = '0;
                n_timer      = '0;
            end
            UOP_TIMER_DEC: begin
                if (r_timer != '0) begin
                    n_timer = r_timer - TIMER_BITS'(1);
                end
            end
            UOP_IDX_INC:  n_index = r_index + CNT_W'(1);
            UOP_IDX_ZERO: n_index = '0;
            UOP_GO_IDLE: begin
                n_phase      = PH_IDLE;
                n_index      = '0;
                n_blink_left = '0;
                n_timer      = '0;
            end
            UOP_START_FAULT: begin
                if (r_rd_code[11:8] != 4'd0) begin
                    n_blink_left = {4'd0, r_rd_code[11:8]};
                    n_phase      = PH_RED_ON;
                    n_timer      = dur_to_timer(r_blink);
                end else begin
                    n_phase = PH_MID_GAP;
                    n_timer = dur_to_timer(r_mid_gap);
                end
            end
            UOP_ADVANCE: begin
                case (r_phase)
                    PH_RED_ON: begin
                        n_phase = PH_RED_OFF;
                        n_timer = dur_to_timer(r_blink);
                    end
                    PH_RED_OFF: begin
                        n_blink_left = bl_dec;
                        if (bl_dec != 8'd0) begin
                            n_phase = PH_RED_ON;
                            n_timer = dur_to_timer(r_blink);
                        end else begin
                            n_phase = PH_MID_GAP;
                            n_timer = dur_to_timer(r_mid_gap);
                        end
                    end
                    PH_MID_GAP: begin
                        if (r_rd_code[7:0] != 8'd0) begin
                            n_blink_left = r_rd_code[7:0];
                            n_phase      = PH_GRN_ON;
                            n_timer      = dur_to_timer(r_blink);
                        end else begin
                            n_phase = PH_END_GAP;
                            n_timer = dur_to_timer(r_end_gap);
                        end
                    end
                    PH_GRN_ON: begin
                        n_phase = PH_GRN_OFF;
                        n_timer = dur_to_timer(r_blink);
                    end
                    PH_GRN_OFF: begin
                        n_blink_left = bl_dec;
                        if (bl_dec != 8'd0) begin
                            n_phase = PH_GRN_ON;
                            n_timer = dur_to_timer(r_blink);
                        end else begin
                            n_phase = PH_END_GAP;
                            n_timer = dur_to_timer(r_end_gap);
                        end
                    end
                    PH_END_GAP: begin
                        // buzzer pattern by severity
                        case (r_rd_sev)
                            SEV_WARNING: begin
                                n_blink_left = 8'd1;
                                n_phase      = PH_BUZ_ON;
                                n_timer      = dur_to_timer(r_blink);
                            end
                            SEV_ERROR: begin
                                n_blink_left = 8'd2;
                                n_phase      = PH_BUZ_ON;
                                n_timer      = dur_to_timer(r_blink);
                            end
                            SEV_FATAL: begin
                                n_blink_left = 8'd1;
                                n_phase      = PH_BUZ_ON;
                                n_timer      = dur_to_timer(r_long_beep);
                            end
                            default: begin
                                n_phase = PH_FAULT_GAP;
                                n_timer = dur_to_timer(r_fault_gap);
                            end
                        endcase
                    end
                    PH_BUZ_ON: begin
                        if (r_rd_sev == SEV_ERROR) begin
                            n_phase = PH_BUZ_OFF;
                            n_timer = dur_to_timer(r_blink);
                        end else begin
                            n_phase = PH_FAULT_GAP;
                            n_timer = dur_to_timer(r_fault_gap);
                        end
                    end
                    PH_BUZ_OFF: begin
                        n_blink_left = bl_dec;
                        if (bl_dec != 8'd0) begin
                            n_phase = PH_BUZ_ON;
                            n_timer = dur_to_timer(r_blink);
                        end else begin
                            n_phase = PH_FAULT_GAP;
                            n_timer = dur_to_timer(r_fault_gap);
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
            default: ;
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_map        <= '0;
            r_crit       <= 1'b0;
            r_phase      <= PH_IDLE;
            r_index      <= '0;
            r_blink_left <= '0;
            r_timer      <= '0;
        end else begin
            r_count      <= n_count;
            r_map        <= n_map;
            r_crit       <= n_crit;
            r_phase      <= n_phase;
            r_index      <= n_index;
            r_blink_left <= n_blink_left;
            r_timer      <= n_timer;
        end
    end

    // Result register, loaded on the emit step
    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            o_rsp.red_led       <= (r_phase == PH_RED_ON);
            o_rsp.green_led     <= (r_phase == PH_GRN_ON);
            o_rsp.buzzer_on     <= (r_phase == PH_BUZ_ON);
            o_rsp.playing       <= (r_phase != PH_IDLE);
            o_rsp.logged_count  <= r_count;
            o_rsp.module_bitmap <= r_map;
            o_rsp.critical_seen <= r_crit;
        end
    end

endmodule
